[rtl/assert_macros.svh]
// Assertion macros shared by the receiver RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle that forces a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lpfr_pkg.sv]
`timescale 1ns / 1ps
// Constants and types for the length-prefixed frame receiver.
// No dependencies; used by length_prefixed_frame_receiver_top.
package lpfr_pkg;

    // Buffer sizes.
    localparam int BUF_DEPTH  = 32;
    localparam int HELD_BYTES = 30;
    localparam int POS_W      = $clog2(BUF_DEPTH);
    localparam int HELD_IDX_W = $clog2(HELD_BYTES);

    // Length compare width: a payload length byte plus overhead.
    localparam int NEED_W = 9;

    // Frame format.
    localparam logic [7:0]        SYNC_BYTE      = 8'h5a;
    localparam logic [7:0]        TYPE_LATCH     = 8'h45;
    localparam logic [NEED_W-1:0] FRAME_OVERHEAD = NEED_W'(5);

    // Field widths and stream widths.
    localparam int KIND_W      = 2;
    localparam int RD_IDX_W    = 5;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // Item kinds carried in tuser.
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

    // One result item, frame_ready in the lowest bit.
    typedef struct packed {
        logic [7:0] read_byte;
        logic       frame_dropped;
        logic       frame_latched;
        logic       frame_ready;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

[rtl/length_prefixed_frame_receiver_top.sv]
`timescale 1ns / 1ps
// Length-prefixed frame receiver: byte stream deframer with a held frame.
// Depends on lpfr_pkg and assert_macros.svh.
//
// Usage:
//   Input items arrive on the s_axis channel. tuser carries the kind
//   (received byte, release held frame, read held byte) and tdata carries
//   the received byte and the held-frame read index.
//   Each input item yields exactly one result item on the m_axis channel
//   with the ready flag, the latched and dropped flags and the read byte.
//   An accepted item is first loaded into the input register, and the item
//   then moves through the frame logic into the result register once that
//   register is free. Throughput is one item per cycle while m_axis_tready
//   stays high; the whole frame check and the parallel copy of the receive
//   buffer into the held frame fit between those two registers.
//   If the downstream side holds m_axis_tready low, the result register
//   holds its item, the input register still takes one more item, and then
//   s_axis_tready drops until the result is taken.
//   Reset clears the receive buffer, the held frame, the position counter,
//   the ready flag and the valid bits of both pipeline registers.
`include "assert_macros.svh"

module length_prefixed_frame_receiver_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Bits from low: rx_byte [7:0], read_index [12:8], zero fill.
    input  logic [lpfr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Bits from low: kind [1:0].
    input  logic [lpfr_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Bits from low: frame_ready, frame_latched, frame_dropped,
    // read_byte [10:3], zero fill.
    output logic [lpfr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // Input register.
    logic                              in_vld_reg;
    logic [lpfr_pkg::KIND_W-1:0]       in_kind_reg;
    logic [7:0]                        in_byte_reg;
    logic [lpfr_pkg::RD_IDX_W-1:0]     in_idx_reg;

    // Result register.
    logic                              out_vld_reg;
    lpfr_pkg::result_t                 out_res_reg;
    lpfr_pkg::result_t                 out_res_next;

    // Frame state.
    logic [7:0]                        store_reg [lpfr_pkg::BUF_DEPTH];
    logic [7:0]                        store_next [lpfr_pkg::BUF_DEPTH];
    logic [7:0]                        held_reg [lpfr_pkg::HELD_BYTES];
    logic [7:0]                        held_copy [lpfr_pkg::HELD_BYTES];
    logic [lpfr_pkg::POS_W-1:0]        pos_reg;
    logic [lpfr_pkg::POS_W-1:0]        pos_next;
    logic                              ready_reg;
    logic                              ready_next;

    logic                              out_free;
    logic                              proc;
    logic                              take_byte;
    logic                              latch;
    logic                              dropped;
    logic [lpfr_pkg::POS_W:0]          pos_inc;
    logic [lpfr_pkg::NEED_W-1:0]       pos_cmp;
    logic [lpfr_pkg::NEED_W-1:0]       need;
    logic [lpfr_pkg::HELD_IDX_W-1:0]   held_idx;
    logic                              idx_ok;

    // Handshake: the result register frees up when empty or being taken.
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign proc          = in_vld_reg && out_free;
    assign s_axis_tready = !in_vld_reg || out_free;
    assign take_byte     = proc && (in_kind_reg == lpfr_pkg::KIND_BYTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata[7:0];
            in_idx_reg  <= s_axis_tdata[8 +: lpfr_pkg::RD_IDX_W];
        end
    end

    // Receive buffer with the current byte merged in at the position.
    always_comb
    begin
        for (int i = 0; i < lpfr_pkg::BUF_DEPTH; i++)
        begin
            store_next[i] = store_reg[i];
        end
        store_next[pos_reg] = in_byte_reg;
    end

    // Held frame image: buffer positions past the buffer end read as zero.
    for (genvar g = 0; g < lpfr_pkg::HELD_BYTES; g++)
    begin : g_copy
        if (g < lpfr_pkg::BUF_DEPTH)
        begin : g_in
            assign held_copy[g] = store_next[g];
        end
        else
        begin : g_out
            assign held_copy[g] = 8'h00;
        end
    end

    // Position and frame completion.
    assign pos_inc = {1'b0, pos_reg} + 1'b1;
    assign pos_cmp = lpfr_pkg::NEED_W'(pos_inc);
    assign need    = lpfr_pkg::NEED_W'(store_next[3]) + lpfr_pkg::FRAME_OVERHEAD;

    always_comb
    begin
        pos_next = pos_inc[lpfr_pkg::POS_W-1:0];
        latch    = 1'b0;
        dropped  = 1'b0;
        if (store_next[0] != lpfr_pkg::SYNC_BYTE)
        begin
            pos_next = '0;
        end
        else if (pos_cmp == lpfr_pkg::NEED_W'(2) && store_next[1] != lpfr_pkg::SYNC_BYTE)
        begin
            pos_next = '0;
        end
        else if (pos_cmp > lpfr_pkg::NEED_W'(3))
        begin
            if (pos_cmp != need)
            begin
                // A frame that fills the buffer without completing is dropped.
                if (pos_cmp == lpfr_pkg::NEED_W'(lpfr_pkg::BUF_DEPTH))
                begin
                    pos_next = '0;
                    dropped  = 1'b1;
                end
            end
            else
            begin
                pos_next = '0;
                latch    = (store_next[2] == lpfr_pkg::TYPE_LATCH) && !ready_reg;
            end
        end
    end

    // Held frame read port.
    assign held_idx = lpfr_pkg::HELD_IDX_W'(in_idx_reg);
    assign idx_ok   = int'(in_idx_reg) < lpfr_pkg::HELD_BYTES;

    // Result of the item in the input register.
    always_comb
    begin
        ready_next   = ready_reg;
        out_res_next = '0;
        case (in_kind_reg)
            lpfr_pkg::KIND_BYTE:
            begin
                out_res_next.frame_latched = latch;
                out_res_next.frame_dropped = dropped;
                if (latch)
                begin
                    ready_next = 1'b1;
                end
            end
            lpfr_pkg::KIND_RELEASE:
            begin
                ready_next = 1'b0;
            end
            lpfr_pkg::KIND_READ:
            begin
                if (idx_ok)
                begin
                    out_res_next.read_byte = held_reg[held_idx];
                end
            end
            default:
            begin
                ready_next = ready_reg;
            end
        endcase
        out_res_next.frame_ready = ready_next;
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ready_reg <= 1'b0;
            for (int i = 0; i < lpfr_pkg::BUF_DEPTH; i++)
            begin
                store_reg[i] <= 8'h00;
            end
            for (int i = 0; i < lpfr_pkg::HELD_BYTES; i++)
            begin
                held_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (proc)
            begin
                ready_reg <= ready_next;
            end
            if (take_byte)
            begin
                pos_reg <= pos_next;
                for (int i = 0; i < lpfr_pkg::BUF_DEPTH; i++)
                begin
                    store_reg[i] <= store_next[i];
                end
                if (latch)
                begin
                    for (int i = 0; i < lpfr_pkg::HELD_BYTES; i++)
                    begin
                        held_reg[i] <= held_copy[i];
                    end
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = lpfr_pkg::OUT_TDATA_W'(out_res_reg);

    // Checks on the frame logic.
    `ASSERT_ALWAYS(a_pos_in_range, int'(pos_reg) < lpfr_pkg::BUF_DEPTH,
        "position counter left the buffer")
    `ASSERT_ALWAYS(a_latch_drop_excl,
        !(out_vld_reg && out_res_reg.frame_latched && out_res_reg.frame_dropped),
        "result both latched and dropped a frame")
    `ASSERT_ALWAYS(a_latch_sets_ready,
        !(out_vld_reg && out_res_reg.frame_latched && !out_res_reg.frame_ready),
        "latched frame without the ready flag")
    `ASSERT_NEXT(a_release_clears, proc && in_kind_reg == lpfr_pkg::KIND_RELEASE,
        !ready_reg, "release item left the ready flag set")

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for length_prefixed_frame_receiver_top: a queued
// stream driver, a predicting deframer and a result checker.
// Depends on lpfr_pkg and the receiver RTL.
module testbench;
    import lpfr_pkg::*;

    // Kind code that the block must ignore.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // One stream item waiting to be sent; hold_off makes the sender wait for
    // every outstanding result before this item goes out.
    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [7:0]          rx_byte;
        logic [RD_IDX_W-1:0] read_index;
        bit                  hold_off;
    } rx_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [KIND_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Items still to send and results still awaited.
    rx_item_t pending_items[$];
    result_t  awaited_results[$];
    int       error_count = 0;
    bit       pause_next = 1'b0;

    // Predicted deframer state.
    logic [7:0] shadow_store [BUF_DEPTH];
    logic [7:0] shadow_held  [HELD_BYTES];
    int unsigned shadow_pos = 0;
    logic       shadow_ready = 1'b0;

    // Sender burst and gap counters.
    int burst_left = 8;
    int gap_left = 0;

    // Receiver stall pattern.
    logic [15:0] stall_pattern = 16'hffff;
    int          stall_phase = 0;

    length_prefixed_frame_receiver_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Predict the result of one accepted item and advance the shadow state.
    function automatic result_t deframe_step(input logic [KIND_W-1:0] kind,
                                             input logic [7:0] rx_byte,
                                             input logic [RD_IDX_W-1:0] read_index);
        result_t r;
        int unsigned need;
        r = '0;
        case (kind)
            KIND_BYTE:
            begin
                if (shadow_pos >= BUF_DEPTH)
                    shadow_pos = 0;
                shadow_store[shadow_pos] = rx_byte;
                shadow_pos++;
                if (shadow_store[0] != SYNC_BYTE)
                    shadow_pos = 0;
                if (shadow_pos == 2 && shadow_store[1] != SYNC_BYTE)
                    shadow_pos = 0;
                if (shadow_pos > 3)
                begin
                    need = int'(shadow_store[3]) + int'(FRAME_OVERHEAD);
                    if (shadow_pos != need)
                    begin
                        // Frame filled the buffer without completing: dropped.
                        if (shadow_pos >= BUF_DEPTH)
                        begin
                            shadow_pos = 0;
                            r.frame_dropped = 1'b1;
                        end
                    end
                    else
                    begin
                        // Complete frame; only a latch-type frame into an
                        // empty holder is copied.
                        if (shadow_store[2] == TYPE_LATCH && !shadow_ready)
                        begin
                            for (int i = 0; i < HELD_BYTES; i++)
                                shadow_held[i] = (i < BUF_DEPTH) ? shadow_store[i] : 8'h00;
                            shadow_ready = 1'b1;
                            r.frame_latched = 1'b1;
                        end
                        shadow_pos = 0;
                    end
                end
            end
            KIND_RELEASE:
                shadow_ready = 1'b0;
            KIND_READ:
                if (read_index < HELD_BYTES)
                    r.read_byte = shadow_held[read_index];
            default:
                ;
        endcase
        r.frame_ready = shadow_ready;
        return r;
    endfunction

    task automatic push_item(input logic [KIND_W-1:0] kind, input logic [7:0] rx_byte,
                             input logic [RD_IDX_W-1:0] read_index);
        rx_item_t it;
        it.kind = kind;
        it.rx_byte = rx_byte;
        it.read_index = read_index;
        it.hold_off = pause_next;
        pause_next = 1'b0;
        pending_items.push_back(it);
    endtask

    // Queue a frame header and its tail; an oversized frame stops at the
    // buffer depth, where the block drops it.
    task automatic push_frame(input logic [7:0] frame_type, input logic [7:0] length);
        int total;
        total = int'(length) + 5;
        if (total > BUF_DEPTH)
            total = BUF_DEPTH;
        push_item(KIND_BYTE, SYNC_BYTE, 5'($urandom));
        push_item(KIND_BYTE, SYNC_BYTE, 5'($urandom));
        push_item(KIND_BYTE, frame_type, 5'($urandom));
        push_item(KIND_BYTE, length, 5'($urandom));
        for (int i = 4; i < total; i++)
            push_item(KIND_BYTE, 8'($urandom), 5'($urandom));
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    initial
    begin
        foreach (shadow_store[i])
            shadow_store[i] = 8'h00;
        foreach (shadow_held[i])
            shadow_held[i] = 8'h00;
    end

    // Driver: presents queued items in bursts with random gaps and predicts
    // each item as it is accepted.
    always @(posedge clk)
    begin : drive_proc
        bit took;
        bit send;
        rx_item_t nxt;
        if (rst_n)
        begin
            took = s_axis_tvalid && s_axis_tready;
            if (took)
                awaited_results.push_back(deframe_step(s_axis_tuser, s_axis_tdata[7:0],
                                                       s_axis_tdata[12:8]));
            if (took || !s_axis_tvalid)
            begin
                send = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_items.size() != 0 &&
                         !(pending_items[0].hold_off && awaited_results.size() != 0))
                begin
                    nxt = pending_items.pop_front();
                    send = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                s_axis_tvalid <= send;
                if (send)
                begin
                    s_axis_tdata <= {3'b000, nxt.read_index, nxt.rx_byte};
                    s_axis_tuser <= nxt.kind;
                end
            end
        end
    end

    // Monitor: stalls on its own pattern and checks each result item.
    always @(posedge clk)
    begin : monitor_proc
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[RESULT_W-1:0];
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none, actual %h",
                             $time, got);
                    error_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("frame_ready", want.frame_ready, got.frame_ready);
                    check_field("frame_latched", want.frame_latched, got.frame_latched);
                    check_field("frame_dropped", want.frame_dropped, got.frame_dropped);
                    check_field("read_byte", want.read_byte, got.read_byte);
                end
            end
            if (stall_phase == 15)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pattern = 16'hffff;
                    1: stall_pattern = 16'($urandom);
                    2: stall_pattern = 16'($urandom) & 16'($urandom);
                    default: stall_pattern = 16'($urandom) | 16'($urandom);
                endcase
            end
            stall_phase = (stall_phase + 1) % 16;
            m_axis_tready <= stall_pattern[stall_phase];
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int directed_count;
        int pick;
        logic [7:0] ftype;
        logic [7:0] flen;

        // Directed: read after reset, latch, reads at both ends and past the
        // end, latch while ready, release, unused kind and broken sync.
        push_item(KIND_READ, 8'hff, 5'd0);
        push_item(KIND_BYTE, SYNC_BYTE, 5'd31);
        push_item(KIND_BYTE, SYNC_BYTE, 5'd0);
        push_item(KIND_BYTE, TYPE_LATCH, 5'd31);
        push_item(KIND_BYTE, 8'h00, 5'd0);
        push_item(KIND_BYTE, 8'hff, 5'd31);
        push_item(KIND_READ, 8'h00, 5'd4);
        push_item(KIND_READ, 8'hff, 5'd29);
        push_item(KIND_READ, 8'h00, 5'd31);
        push_item(KIND_READ, 8'h00, 5'd30);
        push_frame(TYPE_LATCH, 8'd0);
        push_item(KIND_RELEASE, 8'hff, 5'd31);
        push_item(KIND_UNUSED, 8'hff, 5'd31);
        push_item(KIND_BYTE, 8'h00, 5'd0);
        push_item(KIND_BYTE, SYNC_BYTE, 5'd0);
        push_item(KIND_BYTE, 8'h00, 5'd0);
        push_frame(8'h00, 8'd1);
        directed_count = pending_items.size();

        // Random: mostly well-formed frames with random content, plus
        // releases, reads, ignored kinds, noise and cut-off frames.
        pause_next = 1'b1;
        while (pending_items.size() < directed_count + 900)
        begin
            if ($urandom_range(0, 49) == 0)
                pause_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                ftype = ($urandom_range(0, 2) != 0) ? TYPE_LATCH : 8'($urandom);
                case ($urandom_range(0, 24))
                    0, 1: flen = 8'd27;
                    2: flen = 8'd255;
                    3, 4: flen = 8'($urandom_range(28, 254));
                    default: flen = 8'($urandom_range(0, 12));
                endcase
                push_frame(ftype, flen);
            end
            else if (pick < 70)
                push_item(KIND_RELEASE, 8'($urandom), 5'($urandom));
            else if (pick < 85)
                push_item(KIND_READ, 8'($urandom), 5'($urandom));
            else if (pick < 90)
                push_item(KIND_UNUSED, 8'($urandom), 5'($urandom));
            else if (pick < 95)
                push_item(KIND_BYTE, ($urandom_range(0, 1) == 0) ? SYNC_BYTE : 8'($urandom),
                          5'($urandom));
            else
            begin
                push_item(KIND_BYTE, SYNC_BYTE, 5'($urandom));
                repeat ($urandom_range(1, 3))
                    push_item(KIND_BYTE, 8'($urandom), 5'($urandom));
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to go out and every result to come back.
        do
            @(posedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/lpfr_pkg.sv
rtl/length_prefixed_frame_receiver_top.sv
dv/testbench.sv
